FILE: hw/rtl/et_pkg.sv
// ============================================================================
// et_pkg: shared types and constants of the expression tokenizer
// Token kinds, character codes, position limits and the record that carries
// the tokens from the tokenizer core to the result queue.
// ============================================================================
package et_pkg;

    localparam int POSITION_LIMIT = 65536;
    localparam int POS_W          = 16;
    localparam int VALUE_W        = 63;
    localparam int CHAR_W         = 8;
    localparam int KIND_W         = 4;

    localparam int POS_CAP_INT = ((POSITION_LIMIT - 1) < 65535) ? (POSITION_LIMIT - 1) : 65535;
    localparam logic [POS_W-1:0] POS_CAP = POS_W'(POS_CAP_INT);

    // Result queue depth and its index widths.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_INT     = 4'd0,
        KIND_PLUS    = 4'd1,
        KIND_MINUS   = 4'd2,
        KIND_STAR    = 4'd3,
        KIND_SLASH   = 4'd4,
        KIND_LPAREN  = 4'd5,
        KIND_RPAREN  = 4'd6,
        KIND_END     = 4'd7,
        KIND_INVALID = 4'd8
    } kind_t;

    localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CHAR_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CHAR_RPAREN = 8'h29;

    typedef struct packed {
        kind_t               kind;
        logic [VALUE_W-1:0]  value;
        logic [POS_W-1:0]    start;
        logic                last;
    } token_t;

    // Up to two tokens produced by one character, first one in order first.
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } push_t;

endpackage

FILE: hw/rtl/expression_tokenizer.sv
// ============================================================================
// expression_tokenizer: streaming arithmetic-expression tokenizer
// Takes one character per request and returns the tokens of an integer
// expression. A character is registered on acceptance and tokenized from that
// register; its tokens are written into the result queue, which feeds the output.
// One character is accepted per cycle while the four-entry result queue has
// room for two. Tokens leave one per cycle unless stalled. A character that
// closes a number and also yields its own token gives two tokens, but it always
// follows a digit, which gives none. So while the output takes a token every
// cycle, the queue never holds more than two tokens and the input never
// stalls. The input stalls only after the output has been held off.
// ============================================================================
module expression_tokenizer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         char_valid,
    output logic                         char_stall,
    input  logic [et_pkg::CHAR_W-1:0]    char_code,
    output logic                         token_valid,
    input  logic                         token_stall,
    output logic [et_pkg::KIND_W-1:0]    token_kind,
    output logic [et_pkg::VALUE_W-1:0]   token_value,
    output logic [et_pkg::POS_W-1:0]     token_start,
    output logic                         last_of_run
);
    import et_pkg::*;

    logic                 char_valid_reg;
    logic [CHAR_W-1:0]    char_reg;
    logic                 fire;
    logic                 room;
    push_t                push;
    token_t               token;

    assign fire       = char_valid_reg && room;
    assign char_stall = char_valid_reg && !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid_reg <= 1'b0;
        end
        else if (!char_stall)
        begin
            char_valid_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            char_reg <= char_code;
        end
    end

    et_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .char_code (char_reg),
        .push      (push)
    );

    et_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .room        (room),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token       (token)
    );

    assign token_kind  = token.kind;
    assign token_value = token.value;
    assign token_start = token.start;
    assign last_of_run = token.last;

endmodule

FILE: hw/rtl/et_core.sv
// ============================================================================
// et_core: tokenizer state and per-character token logic
// Holds the open digit run and the position counter, and turns one character
// into zero, one or two tokens combinationally.
// ============================================================================
module et_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  logic [et_pkg::CHAR_W-1:0]   char_code,
    output et_pkg::push_t               push
);
    import et_pkg::*;

    logic                 in_number_reg, in_number_next;
    logic                 overflow_reg, overflow_next;
    logic [VALUE_W-1:0]   acc_reg, acc_next;
    logic [POS_W-1:0]     num_start_reg, num_start_next;
    logic [POS_W-1:0]     pos_reg, pos_next;

    logic                 is_digit;
    logic                 is_blank;
    logic                 is_nul;
    logic [3:0]           digit;
    logic [VALUE_W+3:0]   acc_x10_sum;
    logic                 sum_overflow;
    logic [POS_W-1:0]     pos_advanced;
    logic                 flush;
    logic                 has_char_tok;
    token_t               flush_tok;
    token_t               char_tok;
    kind_t                op_kind;

    assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign is_nul   = (char_code == CHAR_NUL);
    assign is_blank = (char_code == CHAR_SPACE) ||
                      ((char_code >= CHAR_TAB) && (char_code <= CHAR_CR));
    assign digit    = 4'(char_code - CHAR_ZERO);

    // acc * 10 + digit; any bit above the value width means the run overflowed.
    assign acc_x10_sum = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                       + {{VALUE_W{1'b0}}, digit};
    assign sum_overflow = |acc_x10_sum[VALUE_W+3:VALUE_W];

    assign pos_advanced = (pos_reg < POS_CAP) ? (pos_reg + 1'b1) : pos_reg;

    always_comb
    begin
        case (char_code)
            CHAR_PLUS:   op_kind = KIND_PLUS;
            CHAR_MINUS:  op_kind = KIND_MINUS;
            CHAR_STAR:   op_kind = KIND_STAR;
            CHAR_SLASH:  op_kind = KIND_SLASH;
            CHAR_LPAREN: op_kind = KIND_LPAREN;
            CHAR_RPAREN: op_kind = KIND_RPAREN;
            default:     op_kind = KIND_INVALID;
        endcase
    end

    always_comb
    begin
        flush        = in_number_reg && !is_digit;
        has_char_tok = !is_digit && !is_blank;

        flush_tok.kind  = overflow_reg ? KIND_INVALID : KIND_INT;
        flush_tok.value = overflow_reg ? '0 : acc_reg;
        flush_tok.start = num_start_reg;
        flush_tok.last  = !has_char_tok;

        char_tok.kind  = is_nul ? KIND_END : op_kind;
        char_tok.value = '0;
        char_tok.start = pos_reg;
        char_tok.last  = 1'b1;

        push.first  = flush ? flush_tok : char_tok;
        push.second = char_tok;
        if (fire)
        begin
            push.count = {1'b0, flush} + {1'b0, has_char_tok};
        end
        else
        begin
            push.count = 2'd0;
        end
    end

    always_comb
    begin
        in_number_next = in_number_reg;
        overflow_next  = overflow_reg;
        acc_next       = acc_reg;
        num_start_next = num_start_reg;
        pos_next       = pos_reg;
        if (fire)
        begin
            if (is_digit)
            begin
                if (!in_number_reg)
                begin
                    in_number_next = 1'b1;
                    overflow_next  = 1'b0;
                    acc_next       = {{(VALUE_W-4){1'b0}}, digit};
                    num_start_next = pos_reg;
                end
                else if (!overflow_reg)
                begin
                    if (sum_overflow)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = acc_x10_sum[VALUE_W-1:0];
                    end
                end
                pos_next = pos_advanced;
            end
            else
            begin
                in_number_next = 1'b0;
                overflow_next  = 1'b0;
                acc_next       = '0;
                pos_next       = is_nul ? '0 : pos_advanced;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_number_reg <= 1'b0;
            overflow_reg  <= 1'b0;
            acc_reg       <= '0;
            num_start_reg <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            in_number_reg <= in_number_next;
            overflow_reg  <= overflow_next;
            acc_reg       <= acc_next;
            num_start_reg <= num_start_next;
            pos_reg       <= pos_next;
        end
    end

`ifndef ASSERT_OFF
    a_overflow_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> in_number_reg)
        else $error("overflow flag set outside a digit run");

    a_digit_no_token: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_digit) |-> (push.count == 2'd0))
        else $error("digit produced a token");

    a_pair_last_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> (!push.first.last && push.second.last))
        else $error("wrong last flags on a token pair");
`endif

endmodule

FILE: hw/rtl/et_queue.sv
// ============================================================================
// et_queue: result queue of the expression tokenizer
// Four-entry token queue that takes up to two tokens a cycle and hands one
// token a cycle to the output channel while token_stall is low.
// ============================================================================
module et_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  et_pkg::push_t               push,
    output logic                        room,
    output logic                        token_valid,
    input  logic                        token_stall,
    output et_pkg::token_t              token
);
    import et_pkg::*;

    token_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                pop;

    // Room is kept for a full pair of tokens.
    assign room        = (count_reg <= 3'd2);
    assign token_valid = (count_reg != '0);
    assign token       = mem[rd_ptr_reg];
    assign pop         = token_valid && !token_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push.count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push.count} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + 2'd1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("result queue count out of range");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> room)
        else $error("tokens pushed into a full result queue");
`endif

endmodule
